// ===== hdl/mbps_pkg.sv =====
// Shared constants and types for the missing block priority sorter.
// No dependencies; used by missing_block_priority_sorter_core and mbps_sorter.
package mbps_pkg;

  localparam int DEF_NUM_BLOCKS = 1024;
  localparam int DEF_MAX_OWN    = 64;

  localparam int FREQ_W   = 16;
  localparam int OUT_ID_W = 10;
  localparam int IN_ID_W  = 16;
  localparam int CMD_W    = 2;

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // Command codes of the input channel
  localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OWN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEIGH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

  typedef struct packed {
    logic clear;   // empty all cells
    logic insert;  // insert a new key in order
    logic shift;   // pop the head cell
  } sort_ctl_t;

endpackage

// ===== hdl/missing_block_priority_sorter_core.sv =====
// Missing block priority sorter: control, frequency histogram and own list.
// Depends on mbps_pkg, mbps_ram and mbps_sorter.
//
// Input channel (in_valid / in_stall): in_command with in_block_id.
//   begin clears the histogram and the own list, own counts an ID and keeps
//   it, neighbor only counts it, finish emits the kept IDs by frequency
//   (highest first, smaller ID first on ties). Out-of-range IDs are ignored.
// Output channel (out_valid / out_stall): out_block_id_out, out_frequency_out
//   and out_last on the final entry. Empty own list: finish emits nothing.
// Steps per item, set by the histogram RAM and its registered read:
//   own / neighbor with a valid ID: read, then write back the count
//   invalid ID or empty finish: taken with no further work
//   begin: a clearing pass over the histogram RAM
//   finish with n entries: load the sorter, then n transfers.
// Reset runs the same clearing pass; in_stall is high meanwhile. Results wait
// in an output register while out_stall is high; the next input item is
// taken once the last result has reached that register.
module missing_block_priority_sorter_core #(
  parameter int NUM_BLOCKS = mbps_pkg::DEF_NUM_BLOCKS,
  parameter int MAX_OWN    = mbps_pkg::DEF_MAX_OWN
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mbps_pkg::CMD_W-1:0]           in_command,
  input  logic signed [mbps_pkg::IN_ID_W-1:0]  in_block_id,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mbps_pkg::OUT_ID_W-1:0]        out_block_id_out,
  output logic [mbps_pkg::FREQ_W-1:0]          out_frequency_out,
  output logic                                 out_last
);

  localparam int AW  = $clog2(NUM_BLOCKS);
  localparam int OAW = (MAX_OWN > 1) ? $clog2(MAX_OWN) : 1;
  localparam int OCW = $clog2(MAX_OWN + 1);
  localparam int FW  = mbps_pkg::FREQ_W;
  localparam int OW  = mbps_pkg::OUT_ID_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_COUNT = 5'b00100,
    S_LOAD  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_idx_r, clr_idx_nxt;
  logic [AW-1:0]   cnt_idx_r, cnt_idx_nxt;
  logic [OCW-1:0]  own_count_r, own_count_nxt;
  logic [OCW-1:0]  iss_r, iss_nxt;
  logic [OCW-1:0]  ins_cnt_r, ins_cnt_nxt;
  logic [OCW-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic            s1_v_r, s1_v_nxt;
  logic            s2_v_r, s2_v_nxt;
  logic [AW-1:0]   id2_r, id2_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [OW-1:0]   out_id_r, out_id_nxt;
  logic [FW-1:0]   out_freq_r, out_freq_nxt;
  logic            out_last_r, out_last_nxt;

  logic            in_acc;
  logic            id_ok;
  logic [AW-1:0]   in_idx;
  logic            own_room;
  logic            out_load;
  logic            emit_last;
  logic [AW+OW-1:0] head_ext;

  logic            freq_we;
  logic [AW-1:0]   freq_wa, freq_ra;
  logic [FW-1:0]   freq_wd, freq_rd;
  logic            own_we;
  logic [AW-1:0]   own_rd;

  mbps_pkg::sort_ctl_t sort_ctl;
  logic [AW-1:0]   head_id;
  logic [FW-1:0]   head_freq;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Negative IDs and IDs at or above NUM_BLOCKS are dropped
  assign id_ok    = !in_block_id[mbps_pkg::IN_ID_W-1] &&
                    ({1'b0, in_block_id} < 17'(NUM_BLOCKS));
  assign in_idx   = in_block_id[AW-1:0];
  assign own_room = (own_count_r < OCW'(MAX_OWN));

  assign own_we    = in_acc && (in_command == mbps_pkg::CMD_OWN) && id_ok && own_room;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = (emit_cnt_r == (own_count_r - OCW'(1)));
  assign head_ext  = (AW + OW)'(head_id);

  // Histogram RAM port control
  always_comb begin
    freq_we = 1'b0;
    freq_wa = cnt_idx_r;
    freq_wd = (freq_rd == mbps_pkg::FREQ_MAX) ? freq_rd : (freq_rd + FW'(1));
    freq_ra = (state_r == S_LOAD) ? own_rd : in_idx;
    case (state_r)
      S_CLEAR: begin
        freq_we = 1'b1;
        freq_wa = clr_idx_r;
        freq_wd = '0;
      end
      S_COUNT: begin
        freq_we = 1'b1;
      end
      default: begin
        freq_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    cnt_idx_nxt   = cnt_idx_r;
    own_count_nxt = own_count_r;
    iss_nxt       = iss_r;
    ins_cnt_nxt   = ins_cnt_r;
    emit_cnt_nxt  = emit_cnt_r;
    s1_v_nxt      = 1'b0;
    s2_v_nxt      = s1_v_r;
    id2_nxt       = own_rd;
    sort_ctl      = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_id_nxt    = out_id_r;
    out_freq_nxt  = out_freq_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_command)
            mbps_pkg::CMD_BEGIN: begin
              own_count_nxt = '0;
              clr_idx_nxt   = '0;
              state_nxt     = S_CLEAR;
            end
            mbps_pkg::CMD_OWN, mbps_pkg::CMD_NEIGH: begin
              if (id_ok) begin
                cnt_idx_nxt = in_idx;
                state_nxt   = S_COUNT;
              end
              if (own_we) begin
                own_count_nxt = own_count_r + OCW'(1);
              end
            end
            mbps_pkg::CMD_FINISH: begin
              if (own_count_r != '0) begin
                iss_nxt        = '0;
                ins_cnt_nxt    = '0;
                emit_cnt_nxt   = '0;
                sort_ctl.clear = 1'b1;
                state_nxt      = S_LOAD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_COUNT: begin
        state_nxt = S_IDLE;
      end
      S_LOAD: begin
        // own list read -> histogram read -> insert, one entry per cycle
        if (iss_r < own_count_r) begin
          s1_v_nxt = 1'b1;
          iss_nxt  = iss_r + OCW'(1);
        end
        if (s2_v_r) begin
          sort_ctl.insert = 1'b1;
          ins_cnt_nxt     = ins_cnt_r + OCW'(1);
          if (ins_cnt_r == (own_count_r - OCW'(1))) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          sort_ctl.shift = 1'b1;
          out_valid_nxt  = 1'b1;
          out_id_nxt     = head_ext[OW-1:0];
          out_freq_nxt   = head_freq;
          out_last_nxt   = emit_last;
          emit_cnt_nxt   = emit_cnt_r + OCW'(1);
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      own_count_r <= '0;
      iss_r       <= '0;
      ins_cnt_r   <= '0;
      emit_cnt_r  <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      own_count_r <= own_count_nxt;
      iss_r       <= iss_nxt;
      ins_cnt_r   <= ins_cnt_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_idx_r  <= cnt_idx_nxt;
    id2_r      <= id2_nxt;
    out_id_r   <= out_id_nxt;
    out_freq_r <= out_freq_nxt;
    out_last_r <= out_last_nxt;
  end

  mbps_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_BLOCKS),
    .AW    (AW)
  ) u_freq_ram (
    .clk   (clk),
    .we    (freq_we),
    .waddr (freq_wa),
    .wdata (freq_wd),
    .raddr (freq_ra),
    .rdata (freq_rd)
  );

  mbps_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_OWN),
    .AW    (OAW)
  ) u_own_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (OAW'(own_count_r)),
    .wdata (in_idx),
    .raddr (OAW'(iss_r)),
    .rdata (own_rd)
  );

  mbps_sorter #(
    .N   (MAX_OWN),
    .IDW (AW),
    .FW  (FW)
  ) u_sorter (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sort_ctl),
    .in_id     (id2_r),
    .in_freq   (freq_rd),
    .head_id   (head_id),
    .head_freq (head_freq)
  );

  assign out_valid         = out_valid_r;
  assign out_block_id_out  = out_id_r;
  assign out_frequency_out = out_freq_r;
  assign out_last          = out_last_r;

  a_own_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    own_count_r <= OCW'(MAX_OWN))
    else $error("own list count above capacity");

  a_count_writeback : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && id_ok && (in_command == mbps_pkg::CMD_OWN ||
     in_command == mbps_pkg::CMD_NEIGH)) |=> (state_r == S_COUNT))
    else $error("counted ID not written back");

  a_insert_in_load : assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (state_r == S_LOAD))
    else $error("sorter insert outside load phase");

  a_emit_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (emit_cnt_r < own_count_r))
    else $error("emit index past own list");

endmodule

// ===== hdl/mbps_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module mbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mbps_sorter.sv =====
// Row of insertion cells that keeps (frequency, id) keys in priority order.
// Depends on mbps_pkg for the control struct.
module mbps_sorter #(
  parameter int N   = 64,
  parameter int IDW = 10,
  parameter int FW  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mbps_pkg::sort_ctl_t ctl,
  input  logic [IDW-1:0]      in_id,
  input  logic [FW-1:0]       in_freq,
  output logic [IDW-1:0]      head_id,
  output logic [FW-1:0]       head_freq
);

  logic [IDW-1:0] cell_id_r  [N];
  logic [FW-1:0]  cell_f_r   [N];
  logic [N-1:0]   cell_v_r;
  logic [IDW-1:0] cell_id_nxt [N];
  logic [FW-1:0]  cell_f_nxt  [N];
  logic [N-1:0]   cell_v_nxt;
  logic [N-1:0]   ahead;

  // ahead[i]: the new key belongs ahead of cell i (empty cells count as after)
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ahead[i] = !cell_v_r[i] || (in_freq > cell_f_r[i]) ||
                 ((in_freq == cell_f_r[i]) && (in_id < cell_id_r[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_id_nxt[i] = cell_id_r[i];
      cell_f_nxt[i]  = cell_f_r[i];
      cell_v_nxt[i]  = cell_v_r[i];
      if (ctl.clear) begin
        cell_v_nxt[i] = 1'b0;
      end else if (ctl.insert) begin
        if (ahead[i]) begin
          if ((i > 0) && ahead[i-1]) begin
            cell_id_nxt[i] = cell_id_r[i-1];
            cell_f_nxt[i]  = cell_f_r[i-1];
            cell_v_nxt[i]  = cell_v_r[i-1];
          end else begin
            cell_id_nxt[i] = in_id;
            cell_f_nxt[i]  = in_freq;
            cell_v_nxt[i]  = 1'b1;
          end
        end
      end else if (ctl.shift) begin
        if (i < N - 1) begin
          cell_id_nxt[i] = cell_id_r[i+1];
          cell_f_nxt[i]  = cell_f_r[i+1];
          cell_v_nxt[i]  = cell_v_r[i+1];
        end else begin
          cell_v_nxt[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_v_r <= '0;
    end else begin
      cell_v_r <= cell_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      cell_id_r[i] <= cell_id_nxt[i];
      cell_f_r[i]  <= cell_f_nxt[i];
    end
  end

  assign head_id   = cell_id_r[0];
  assign head_freq = cell_f_r[0];

endmodule
